// ===== design/mtes_pkg.sv =====
// ============================================================================
// mtes_pkg
// Shared types, codes and the variable-length quantity encoder for the
// midi track event serializer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mtes_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_CHANNEL = 2'd0;
    localparam logic [1:0] CMD_HEADER  = 2'd1;
    localparam logic [1:0] CMD_PAYLOAD = 2'd2;

    // configuration register indexes
    localparam logic CFG_SEQ_CHANNEL = 1'b0;
    localparam logic CFG_USE_EVENT   = 1'b1;

    // status high nibbles of channel events
    localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
    localparam logic [3:0] KIND_AFTERTCH  = 4'hA;
    localparam logic [3:0] KIND_CONTROL   = 4'hB;
    localparam logic [3:0] KIND_PROGRAM   = 4'hC;
    localparam logic [3:0] KIND_PRESSURE  = 4'hD;
    localparam logic [3:0] KIND_PITCH     = 4'hE;

    localparam logic [7:0] STATUS_META    = 8'hFF;
    localparam logic       VLQ_MORE       = 1'b1;

    // input item
    typedef struct packed {
        logic [1:0]  command;
        logic [27:0] tick_delta;
        logic [7:0]  status;
        logic [3:0]  event_channel;
        logic [7:0]  meta_type;
        logic [6:0]  data_first;
        logic [6:0]  data_second;
        logic [27:0] payload_length;
        logic [7:0]  payload_byte;
    } t_in;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out;

    // encoded vlq, byte 0 goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
    } t_vlq;

    // classified item: three byte segments sent in order
    typedef struct packed {
        logic [3:0][7:0] seg_a;
        logic [2:0]      cnt_a;
        logic [2:0][7:0] seg_b;
        logic [1:0]      cnt_b;
        logic [3:0][7:0] seg_c;
        logic [2:0]      cnt_c;
    } t_job;

    // 28-bit value to 1..4 vlq bytes, most significant group first
    function automatic t_vlq vlq_encode(input logic [27:0] v);
        t_vlq r;
        r.bytes = '0;
        if (v[27:21] != 7'd0) begin
            r.cnt      = 3'd4;
            r.bytes[0] = {VLQ_MORE, v[27:21]};
            r.bytes[1] = {VLQ_MORE, v[20:14]};
            r.bytes[2] = {VLQ_MORE, v[13:7]};
            r.bytes[3] = {1'b0, v[6:0]};
        end else if (v[20:14] != 7'd0) begin
            r.cnt      = 3'd3;
            r.bytes[0] = {VLQ_MORE, v[20:14]};
            r.bytes[1] = {VLQ_MORE, v[13:7]};
            r.bytes[2] = {1'b0, v[6:0]};
        end else if (v[13:7] != 7'd0) begin
            r.cnt      = 3'd2;
            r.bytes[0] = {VLQ_MORE, v[13:7]};
            r.bytes[1] = {1'b0, v[6:0]};
        end else begin
            r.cnt      = 3'd1;
            r.bytes[0] = {1'b0, v[6:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/midi_track_event_serializer.sv =====
// an accepted item is written into the job queue, and its first byte then goes out
//   through the registered output stage; one output byte per cycle while a job is
//   queued and the receiver is ready; an item gives 1 to 10 bytes (about 4 for a typical channel event)
// a two-entry job queue lets input items keep arriving while bytes drain
// reset: synchronous active low; empties the queue and output stage, sets
//   sequence channel to 0 and use-event-channel to 1
// ============================================================================
// midi_track_event_serializer
// Serializes midi events into standard midi file track bytes: front end
// classifies items, a short queue decouples it from the byte serializer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_serializer import mtes_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [3:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in        i_item,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out            o_item
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    // classify items
    mtes_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .i_q_full   (q_full),
        .o_ready    (o_ready),
        .o_push     (push),
        .o_job      (push_job)
    );

    // job queue
    mtes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // byte serializer
    mtes_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (pop),
        .i_ready   (i_ready),
        .o_valid   (o_valid),
        .o_item    (o_item)
    );

endmodule

`default_nettype wire

// ===== design/mtes_front.sv =====
// ============================================================================
// mtes_front
// Accepts input items, holds the channel configuration and turns each item
// into a job of up to three byte segments for the queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mtes_front import mtes_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [3:0] i_cfg_data,
    input  wire logic       i_valid,
    input  wire t_in        i_item,
    input  wire logic       i_q_full,
    output logic            o_ready,
    output logic            o_push,
    output t_job            o_job
);

    logic [3:0] r_seq_channel;
    logic       r_use_event;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_channel <= 4'd0;
            r_use_event   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEQ_CHANNEL: r_seq_channel <= i_cfg_data;
                CFG_USE_EVENT:   r_use_event   <= i_cfg_data[0];
                default:         r_seq_channel <= r_seq_channel;
            endcase
        end
    end

    t_vlq       delta_vlq;
    t_vlq       len_vlq;
    logic [3:0] chan;
    logic       is_known;

    assign delta_vlq = vlq_encode(i_item.tick_delta);
    assign len_vlq   = vlq_encode(i_item.payload_length);
    assign chan      = r_use_event ? i_item.event_channel : r_seq_channel;

    // every command but the unused code goes to the queue
    assign is_known = (i_item.command == CMD_CHANNEL) || (i_item.command == CMD_HEADER)
                   || (i_item.command == CMD_PAYLOAD);
    assign o_ready  = !i_q_full;
    assign o_push   = i_valid && !i_q_full && is_known;

    // classify the item into segments
    always_comb begin
        o_job       = '0;
        o_job.cnt_b = 2'd1;
        case (i_item.command)
            CMD_CHANNEL: begin
                o_job.seg_a    = delta_vlq.bytes;
                o_job.cnt_a    = delta_vlq.cnt;
                o_job.seg_b[0] = i_item.status | {4'd0, chan};
                o_job.seg_b[1] = {1'b0, i_item.data_first};
                o_job.seg_b[2] = {1'b0, i_item.data_second};
                case (i_item.status[7:4])
                    KIND_NOTE_OFF, KIND_NOTE_ON, KIND_AFTERTCH,
                    KIND_CONTROL, KIND_PITCH:     o_job.cnt_b = 2'd3;
                    KIND_PROGRAM, KIND_PRESSURE:  o_job.cnt_b = 2'd2;
                    default:                      o_job.cnt_b = 2'd1;
                endcase
            end
            CMD_HEADER: begin
                o_job.seg_a    = delta_vlq.bytes;
                o_job.cnt_a    = delta_vlq.cnt;
                o_job.seg_b[0] = i_item.status;
                o_job.seg_b[1] = i_item.meta_type;
                o_job.cnt_b    = (i_item.status == STATUS_META) ? 2'd2 : 2'd1;
                o_job.seg_c    = len_vlq.bytes;
                o_job.cnt_c    = len_vlq.cnt;
            end
            CMD_PAYLOAD: begin
                o_job.seg_b[0] = i_item.payload_byte;
            end
            default: begin
                o_job.cnt_b = 2'd1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/mtes_queue.sv =====
// ============================================================================
// mtes_queue
// Two-entry job queue between front and back, head shown ahead of the pop.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mtes_queue import mtes_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/mtes_back.sv =====
// ============================================================================
// mtes_back
// Walks the segments of the head job and sends one byte per cycle, unless
// stalled, through a registered output stage, marking each item's last byte.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mtes_back import mtes_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_job i_job,
    output logic      o_pop,
    input  wire logic i_ready,
    output logic      o_valid,
    output t_out      o_item
);

    localparam logic [1:0] SEG_A = 2'd0;
    localparam logic [1:0] SEG_B = 2'd1;
    localparam logic [1:0] SEG_C = 2'd2;

    logic [1:0] r_seg;
    logic [1:0] r_idx;
    logic       r_valid;
    t_out       r_item;

    logic [1:0] cur_seg;
    logic [2:0] cur_cnt;
    logic [7:0] cur_byte;
    logic [2:0] idx_next;
    logic       seg_end;
    logic       item_end;
    logic       step;

    // skip an empty delta segment at the start of a job
    assign cur_seg = (r_seg == SEG_A && i_job.cnt_a == 3'd0) ? SEG_B : r_seg;

    // current byte and segment length
    always_comb begin
        case (cur_seg)
            SEG_A: begin
                cur_byte = i_job.seg_a[r_idx];
                cur_cnt  = i_job.cnt_a;
            end
            SEG_B: begin
                cur_byte = (r_idx == 2'd3) ? 8'd0 : i_job.seg_b[r_idx];
                cur_cnt  = {1'b0, i_job.cnt_b};
            end
            SEG_C: begin
                cur_byte = i_job.seg_c[r_idx];
                cur_cnt  = i_job.cnt_c;
            end
            default: begin
                cur_byte = 8'd0;
                cur_cnt  = 3'd1;
            end
        endcase
    end

    assign idx_next = {1'b0, r_idx} + 3'd1;
    assign seg_end  = (idx_next == cur_cnt);
    assign item_end = seg_end && ((cur_seg == SEG_B && i_job.cnt_c == 3'd0)
                                  || cur_seg == SEG_C);
    assign step     = i_q_valid && (!r_valid || i_ready);
    assign o_pop    = step && item_end;

    // segment and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= SEG_A;
            r_idx <= 2'd0;
        end else if (step) begin
            if (item_end) begin
                r_seg <= SEG_A;
                r_idx <= 2'd0;
            end else if (seg_end) begin
                r_seg <= cur_seg + 2'd1;
                r_idx <= 2'd0;
            end else begin
                r_idx <= idx_next[1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_item.out_byte <= cur_byte;
            r_item.last     <= item_end;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== dv/tb_midi_track_event_serializer.sv =====
// ============================================================================
// tb_midi_track_event_serializer
// Drives channel events, sysex and meta headers, payload bytes and unused
// commands through the serializer under several channel settings, predicts
// the track bytes of every accepted item and checks each output byte and its
// last flag in order, with random sender gaps and receiver stalls.
// ============================================================================
`timescale 1ns / 1ps

module tb_midi_track_event_serializer;
    import mtes_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 40;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;

    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_PATTERN, RX_SLOW} t_rx_mode;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_idx  = 1'b0;
    logic [3:0] i_cfg_data = 4'h0;
    logic       i_valid    = 1'b0;
    logic       o_ready;
    t_in        i_item     = '0;
    logic       o_valid;
    logic       i_ready    = 1'b0;
    t_out       o_item;

    // channel settings as the block should hold them
    logic [3:0] seq_channel_model = 4'h0;
    logic       use_event_model   = 1'b1;

    t_in        pending_items[$];
    t_out       expected_bytes[$];
    logic [7:0] staged_bytes[$];

    int items_queued       = 0;
    int items_accepted     = 0;
    int ignored_items      = 0;
    int bytes_checked      = 0;
    int error_count        = 0;
    int input_stall_cycles = 0;
    int settings_used      = 0;
    int cycles_run         = 0;

    midi_track_event_serializer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    // variable-length quantity, most significant group first
    task automatic append_vlq(input logic [27:0] v);
        int groups;
        groups = 1;
        while (groups < 4 && (v >> (7 * groups)) != 28'd0)
            groups++;
        for (int g = groups - 1; g >= 0; g--)
            staged_bytes.push_back({(g > 0) ? 1'b1 : 1'b0, v[7 * g +: 7]});
    endtask

    // track bytes of one accepted item, last one flagged
    task automatic encode_event(input t_in it);
        logic [3:0] chan;
        t_out       b;
        staged_bytes.delete();
        case (it.command)
            CMD_CHANNEL: begin
                chan = use_event_model ? it.event_channel : seq_channel_model;
                append_vlq(it.tick_delta);
                staged_bytes.push_back(it.status | {4'h0, chan});
                case (it.status[7:4])
                    KIND_NOTE_OFF, KIND_NOTE_ON, KIND_AFTERTCH, KIND_CONTROL,
                    KIND_PITCH: begin
                        staged_bytes.push_back({1'b0, it.data_first});
                        staged_bytes.push_back({1'b0, it.data_second});
                    end
                    KIND_PROGRAM, KIND_PRESSURE: begin
                        staged_bytes.push_back({1'b0, it.data_first});
                    end
                    default: ;
                endcase
            end
            CMD_HEADER: begin
                append_vlq(it.tick_delta);
                staged_bytes.push_back(it.status);
                if (it.status == STATUS_META)
                    staged_bytes.push_back(it.meta_type);
                append_vlq(it.payload_length);
            end
            CMD_PAYLOAD: begin
                staged_bytes.push_back(it.payload_byte);
            end
            default: begin
                ignored_items++;
            end
        endcase
        foreach (staged_bytes[k]) begin
            b.out_byte = staged_bytes[k];
            b.last     = (k == staged_bytes.size() - 1);
            expected_bytes.push_back(b);
        end
    endtask

    // driver: bursts of items with random gaps in between
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                encode_event(i_item);
                items_accepted++;
            end
            if (i_valid && !o_ready) begin
                input_stall_cycles++;
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_item  <= pending_items.pop_front();
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: stall modes of random length, one long hold-off
    t_rx_mode   rx_mode       = RX_STEADY;
    int         mode_left     = 0;
    int         hold_left     = 0;
    bit         hold_done     = 1'b0;
    int         bytes_seen    = 0;
    logic [7:0] ready_pattern = 8'hFF;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                bytes_seen++;
            if (!hold_done && bytes_seen >= HOLD_AFTER && i_valid) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                rx_mode       = t_rx_mode'($urandom_range(0, 3));
                mode_left     = $urandom_range(8, 64);
                ready_pattern = 8'($urandom) | 8'h01;
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_STEADY:  i_ready <= 1'b1;
                    RX_COIN:    i_ready <= ($urandom_range(0, 1) == 1);
                    RX_PATTERN: i_ready <= ready_pattern[0];
                    default:    i_ready <= ($urandom_range(0, 7) == 0);
                endcase
                ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            end
        end
    end

    // monitor: each output byte against the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                flag_error($sformatf("byte %02h last %0b with nothing expected",
                                     o_item.out_byte, o_item.last));
            end else begin
                want = expected_bytes.pop_front();
                if (o_item.out_byte !== want.out_byte)
                    flag_error($sformatf("byte %0d: out_byte %02h, expected %02h",
                                         bytes_checked, o_item.out_byte, want.out_byte));
                if (o_item.last !== want.last)
                    flag_error($sformatf("byte %0d: last %0b, expected %0b",
                                         bytes_checked, o_item.last, want.last));
            end
        end
    end

    function automatic t_in make_item(input logic [1:0] command, input logic [27:0] delta,
                                      input logic [7:0] status, input logic [3:0] chan,
                                      input logic [7:0] meta, input logic [6:0] d0,
                                      input logic [6:0] d1, input logic [27:0] plen,
                                      input logic [7:0] pbyte);
        t_in it;
        it.command        = command;
        it.tick_delta     = delta;
        it.status         = status;
        it.event_channel  = chan;
        it.meta_type      = meta;
        it.data_first     = d0;
        it.data_second    = d1;
        it.payload_length = plen;
        it.payload_byte   = pbyte;
        return it;
    endfunction

    // count with a random number of vlq groups
    function automatic logic [27:0] random_count();
        logic [27:0] v;
        v = 28'($urandom);
        return v >> (7 * $urandom_range(0, 3));
    endfunction

    function automatic t_in random_item(input logic [1:0] command, input logic [7:0] status);
        return make_item(command, random_count(), status, 4'($urandom), 8'($urandom),
                         7'($urandom), 7'($urandom), random_count(), 8'($urandom));
    endfunction

    task automatic queue_item(input t_in it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // mostly well-formed events and sysex/meta runs, some noise
    task automatic queue_random_traffic(input int wanted);
        int         made;
        int         pick;
        int         plen;
        logic [3:0] kind;
        logic [7:0] status;
        t_in        it;
        made = 0;
        while (made < wanted) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                kind = 4'($urandom_range(KIND_NOTE_OFF, KIND_PITCH));
                queue_item(random_item(CMD_CHANNEL, {kind, 4'h0}));
                made++;
            end else if (pick < 75) begin
                case ($urandom_range(0, 3))
                    0:       status = SYSEX_START;
                    1:       status = SYSEX_ESCAPE;
                    2:       status = STATUS_META;
                    default: status = 8'($urandom);
                endcase
                it = random_item(CMD_HEADER, status);
                plen = $urandom_range(0, 5);
                // now and then a header whose payload never follows
                if ($urandom_range(0, 3) != 0)
                    it.payload_length = 28'(plen);
                else
                    plen = 0;
                queue_item(it);
                made++;
                repeat (plen) begin
                    queue_item(random_item(CMD_PAYLOAD, 8'($urandom)));
                    made++;
                end
            end else if (pick < 85) begin
                queue_item(random_item(CMD_PAYLOAD, 8'($urandom)));
                made++;
            end else if (pick < 93) begin
                queue_item(random_item(CMD_CHANNEL, 8'($urandom)));
                made++;
            end else begin
                queue_item(random_item(CMD_UNUSED, 8'($urandom)));
            end
        end
    endtask

    task automatic wait_until_drained();
        while (items_accepted != items_queued || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input logic idx, input logic [3:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SEQ_CHANNEL)
            seq_channel_model = value;
        else
            use_event_model = value[0];
    endtask

    // one channel setting, then a stretch of random traffic
    task automatic run_setting(input logic [3:0] seq_chan, input logic use_event);
        wait_until_drained();
        set_register(CFG_SEQ_CHANNEL, seq_chan);
        set_register(CFG_USE_EVENT, {3'b000, use_event});
        settings_used++;
        queue_random_traffic(PHASE_ITEMS);
    endtask

    // stimulus and end of run
    initial begin
        settings_used = 1;

        // directed items under reset settings
        queue_item(make_item(CMD_CHANNEL, 28'd0, {KIND_NOTE_ON, 4'h0}, 4'h0, 8'h00,
                             7'h00, 7'h00, 28'd0, 8'h00));
        queue_item(make_item(CMD_CHANNEL, 28'h7F, {KIND_NOTE_OFF, 4'h0}, 4'hF, 8'hFF,
                             7'h7F, 7'h7F, 28'hFFFFFFF, 8'hFF));
        queue_item(make_item(CMD_CHANNEL, 28'h80, {KIND_AFTERTCH, 4'h0}, 4'h5, 8'h12,
                             7'h40, 7'h01, 28'd5, 8'h33));
        queue_item(make_item(CMD_CHANNEL, 28'h3FFF, {KIND_CONTROL, 4'h0}, 4'hA, 8'h00,
                             7'h07, 7'h64, 28'd0, 8'h00));
        queue_item(make_item(CMD_CHANNEL, 28'h4000, {KIND_PROGRAM, 4'h0}, 4'h3, 8'hAA,
                             7'h7F, 7'h55, 28'd9, 8'h11));
        queue_item(make_item(CMD_CHANNEL, 28'h1FFFFF, {KIND_PRESSURE, 4'h0}, 4'hC, 8'h55,
                             7'h2A, 7'h7F, 28'd1, 8'h22));
        queue_item(make_item(CMD_CHANNEL, 28'h200000, {KIND_PITCH, 4'h0}, 4'h1, 8'h01,
                             7'h00, 7'h40, 28'd2, 8'h44));
        // status low nibble already set
        queue_item(make_item(CMD_CHANNEL, 28'hFFFFFFF, 8'h95, 4'hA, 8'h00,
                             7'h3C, 7'h7F, 28'd0, 8'h00));
        // high nibble outside the channel kinds: no data bytes
        queue_item(make_item(CMD_CHANNEL, 28'h1234, 8'h70, 4'h6, 8'h00,
                             7'h11, 7'h22, 28'd0, 8'h00));
        queue_item(make_item(CMD_CHANNEL, 28'd0, SYSEX_START, 4'h9, 8'h00,
                             7'h7F, 7'h7F, 28'd0, 8'h00));
        queue_item(make_item(CMD_CHANNEL, 28'd1, STATUS_META, 4'hF, 8'h2F,
                             7'h01, 7'h02, 28'd0, 8'h00));
        // sysex header and its payload
        queue_item(make_item(CMD_HEADER, 28'h60, SYSEX_START, 4'h0, 8'h2F,
                             7'h00, 7'h00, 28'd3, 8'h00));
        queue_item(make_item(CMD_PAYLOAD, 28'd0, 8'h00, 4'h0, 8'h00,
                             7'h00, 7'h00, 28'd0, 8'h00));
        queue_item(make_item(CMD_PAYLOAD, 28'hFFFFFFF, 8'hFF, 4'hF, 8'hFF,
                             7'h7F, 7'h7F, 28'hFFFFFFF, 8'hFF));
        queue_item(make_item(CMD_PAYLOAD, 28'd0, 8'h00, 4'h0, 8'h00,
                             7'h00, 7'h00, 28'd0, 8'h5A));
        // meta and escape headers, the longest one gives the most bytes
        queue_item(make_item(CMD_HEADER, 28'd0, STATUS_META, 4'h7, 8'h2F,
                             7'h00, 7'h00, 28'd0, 8'h00));
        queue_item(make_item(CMD_HEADER, 28'hFFFFFFF, STATUS_META, 4'hF, 8'h51,
                             7'h7F, 7'h7F, 28'hFFFFFFF, 8'hFF));
        queue_item(make_item(CMD_HEADER, 28'h81, SYSEX_ESCAPE, 4'h0, 8'hFF,
                             7'h00, 7'h00, 28'h80, 8'h00));
        // unused command gives nothing
        queue_item(make_item(CMD_UNUSED, 28'hFFFFFFF, 8'hFF, 4'hF, 8'hFF,
                             7'h7F, 7'h7F, 28'hFFFFFFF, 8'hFF));
        queue_item(make_item(CMD_PAYLOAD, 28'd0, 8'h00, 4'h0, 8'h00,
                             7'h00, 7'h00, 28'd0, 8'h80));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_setting(4'hF, 1'b0);
        run_setting(4'h0, 1'b0);
        run_setting(4'($urandom), 1'b1);
        run_setting(4'($urandom), 1'b0);
        run_setting(4'($urandom), 1'b1);

        wait_until_drained();
        if (expected_bytes.size() != 0)
            flag_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));

        $display("summary: %0d items accepted (%0d ignored), %0d bytes checked, %0d settings",
                 items_accepted, ignored_items, bytes_checked, settings_used);
        $display("summary: receiver hold-off of %0d cycles, sender stalled %0d cycles in all",
                 HOLD_CYCLES, input_stall_cycles);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // cycle limit
    initial begin
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("ERROR: timeout after %0d cycles", cycles_run);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
